// ===== design/svd_pkg.sv =====
// ----------------------------------------------------------------------------
// svd_pkg: shared types and constants of the soft-decision viterbi decoder
// Payload structs for the symbol and byte channels, code table and levels.
// ----------------------------------------------------------------------------
package svd_pkg;

  // trellis size and soft levels
  localparam int          NUM_TRELLIS_STATES = 8;
  localparam logic [7:0]  SOFT_ZERO          = 8'hC0;
  localparam logic [7:0]  SOFT_ONE           = 8'h40;
  localparam logic [15:0] COST_MAX           = 16'hFFFF;
  localparam logic [2:0]  STATE_MASK         = 3'h7;

  // input symbol pair
  typedef struct packed {
    logic [7:0] soft_first;
    logic [7:0] soft_second;
    logic       last_pair;
  } svd_in_t;

  // decoded byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } svd_out_t;

  // expected symbol pair per state and input bit: bit1 first symbol, bit0 second
  function automatic logic [1:0] expect_code(input logic [2:0] st, input logic bit_in);
    logic [1:0] code;
    case ({st, bit_in})
      4'd0:    code = 2'd0;
      4'd1:    code = 2'd3;
      4'd2:    code = 2'd1;
      4'd3:    code = 2'd2;
      4'd4:    code = 2'd3;
      4'd5:    code = 2'd0;
      4'd6:    code = 2'd2;
      4'd7:    code = 2'd1;
      4'd8:    code = 2'd3;
      4'd9:    code = 2'd0;
      4'd10:   code = 2'd2;
      4'd11:   code = 2'd1;
      4'd12:   code = 2'd0;
      4'd13:   code = 2'd3;
      4'd14:   code = 2'd1;
      4'd15:   code = 2'd2;
      default: code = 2'd0;
    endcase
    return code;
  endfunction

  // distance of a soft symbol from the ideal level
  function automatic logic [7:0] sym_dist(input logic [7:0] v, input logic is_one);
    logic [7:0] ref_lvl;
    ref_lvl = is_one ? SOFT_ONE : SOFT_ZERO;
    return (v >= ref_lvl) ? (v - ref_lvl) : (ref_lvl - v);
  endfunction

endpackage

// ===== design/soft_viterbi_decoder_k4_top.sv =====
// Path: a pair's first decoded byte passes the input register, add-compare-select into
// the trellis registers and the best-state pick into the output buffer.
// Throughput: one symbol pair per cycle while the output buffer has room; a packet's
// last pair may load two flushed bytes, which the receiver takes one per transfer.
// Reset: synchronous, active low; trellis restarts at state zero, limit_r
// returns to 255, pending pairs and bytes are discarded.
// ----------------------------------------------------------------------------
// soft_viterbi_decoder_k4_top: rate-1/2, 8-state soft-decision viterbi decoder
// Eight parallel ACS units, survivor-history byte output and end-of-packet flush.
// ----------------------------------------------------------------------------
module soft_viterbi_decoder_k4_top
  import svd_pkg::*;
#(
  parameter int TRACEBACK_DEPTH = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  svd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output svd_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int LEAD_MAX = 8 + TRACEBACK_DEPTH;
  localparam int LW       = $clog2(LEAD_MAX + 1);

  // emission plan handed from the ACS stage to the output stage
  typedef struct packed {
    logic       k0;
    logic       k1;
    logic       shift0;
    logic       shift1;
    logic [3:0] dist0;
    logic [3:0] dist1;
    logic       last;
  } plan_t;

  // configuration register
  logic [7:0] limit_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // pipeline control
  logic       s1_valid_r, s2_valid_r;
  svd_in_t    s1_data_r;
  plan_t      s2_plan_r, plan_nxt;
  logic       s1_go, s2_go, s2_free, ob_free, ob_load, ob_pop;
  logic [1:0] ob_cnt_r;
  svd_out_t   ob_r [2];

  assign ob_pop   = out_valid && out_ready;
  assign ob_free  = (ob_cnt_r == 2'd0) || ((ob_cnt_r == 2'd1) && out_ready);
  assign s2_go    = s2_valid_r && (!s2_plan_r.k0 || ob_free);
  assign s2_free  = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s1_go;
  assign ob_load  = s2_go && s2_plan_r.k0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // trellis state; clear_r stands for the reset trellis until the next ACS
  logic [15:0]   cost_r [NUM_TRELLIS_STATES];
  logic [15:0]   hist_r [NUM_TRELLIS_STATES];
  logic [15:0]   cost_nxt [NUM_TRELLIS_STATES];
  logic [15:0]   hist_nxt [NUM_TRELLIS_STATES];
  logic          clear_r;
  logic [LW-1:0] lead_r, lead_nxt;
  logic [7:0]    bytes_r, bytes_nxt;

  // branch metrics for the four expected pairs
  logic [8:0] bm [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      bm[c] = {1'b0, sym_dist(s1_data_r.soft_first, c[1])}
            + {1'b0, sym_dist(s1_data_r.soft_second, c[0])};
    end
  end

  // add-compare-select over the eight states
  always_comb begin
    logic [15:0] src_cost [NUM_TRELLIS_STATES];
    logic [15:0] src_hist [NUM_TRELLIS_STATES];
    logic [2:0]  p0, p1;
    logic        tb;
    logic [16:0] c0, c1;
    logic [15:0] sc0, sc1;
    for (int i = 0; i < NUM_TRELLIS_STATES; i++) begin
      src_cost[i] = clear_r ? ((i == 0) ? 16'd0 : COST_MAX) : cost_r[i];
      src_hist[i] = clear_r ? 16'd0 : hist_r[i];
    end
    for (int t = 0; t < NUM_TRELLIS_STATES; t++) begin
      tb  = t[0];
      p0  = {1'b0, t[2:1]} & STATE_MASK;
      p1  = p0 | 3'd4;
      c0  = {1'b0, src_cost[p0]} + 17'(bm[expect_code(p0, tb)]);
      c1  = {1'b0, src_cost[p1]} + 17'(bm[expect_code(p1, tb)]);
      sc0 = c0[16] ? COST_MAX : c0[15:0];
      sc1 = c1[16] ? COST_MAX : c1[15:0];
      if (sc1 < sc0) begin
        cost_nxt[t] = sc1;
        hist_nxt[t] = {src_hist[p1][14:0], p1[0]};
      end else begin
        cost_nxt[t] = sc0;
        hist_nxt[t] = {src_hist[p0][14:0], p0[0]};
      end
    end
  end

  // output plan from the lead between pairs and output bits
  always_comb begin
    logic [5:0] ld;
    logic       e0, e1, last;
    logic [7:0] bytes1;
    ld     = 6'(lead_r);
    last   = s1_data_r.last_pair;
    e0     = (ld >= 6'(LEAD_MAX)) || (last && (ld >= 6'd1));
    e1     = e0 && last && (ld >= 6'd9);
    plan_nxt.k0     = e0 && (bytes_r < limit_r);
    bytes1          = bytes_r + 8'(plan_nxt.k0);
    plan_nxt.k1     = e1 && (bytes1 < limit_r);
    plan_nxt.shift0 = ld < 6'd8;
    plan_nxt.shift1 = ld < 6'd16;
    plan_nxt.dist0  = 4'(ld - 6'd8);
    plan_nxt.dist1  = 4'(ld - 6'd16);
    plan_nxt.last   = last;
    if (last) begin
      lead_nxt  = '0;
      bytes_nxt = 8'd0;
    end else begin
      lead_nxt  = e0 ? LW'(ld + 6'd1 - 6'd8) : LW'(ld + 6'd1);
      bytes_nxt = bytes1;
    end
  end

  // state update on each ACS transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r <= 1'b1;
      lead_r  <= '0;
      bytes_r <= 8'd0;
    end else if (s1_go) begin
      clear_r <= s1_data_r.last_pair;
      lead_r  <= lead_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      cost_r <= cost_nxt;
      hist_r <= hist_nxt;
    end
  end

  // second stage holds the plan while the trellis holds its costs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_plan_r <= plan_nxt;
    end
  end

  // best state: lowest index among the minimum costs
  logic [2:0]  best;
  logic [15:0] best_hist;

  always_comb begin
    logic [15:0] l1c [4];
    logic [2:0]  l1i [4];
    logic [15:0] l2c [2];
    logic [2:0]  l2i [2];
    for (int i = 0; i < 4; i++) begin
      if (cost_r[2*i+1] < cost_r[2*i]) begin
        l1c[i] = cost_r[2*i+1];
        l1i[i] = 3'(2*i+1);
      end else begin
        l1c[i] = cost_r[2*i];
        l1i[i] = 3'(2*i);
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (l1c[2*i+1] < l1c[2*i]) begin
        l2c[i] = l1c[2*i+1];
        l2i[i] = l1i[2*i+1];
      end else begin
        l2c[i] = l1c[2*i];
        l2i[i] = l1i[2*i];
      end
    end
    best      = (l2c[1] < l2c[0]) ? l2i[1] : l2i[0];
    best_hist = hist_r[best];
  end

  // byte extraction
  svd_out_t res0, res1;

  always_comb begin
    logic [15:0] sh0, sh1;
    sh0 = best_hist >> s2_plan_r.dist0;
    sh1 = best_hist >> s2_plan_r.dist1;
    res0.data_byte  = s2_plan_r.shift0 ? {best_hist[6:0], best[0]} : sh0[7:0];
    res0.packet_end = s2_plan_r.last && !s2_plan_r.k1;
    res1.data_byte  = s2_plan_r.shift1 ? {best_hist[6:0], best[0]} : sh1[7:0];
    res1.packet_end = s2_plan_r.last;
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= 2'd0;
    end else if (ob_load) begin
      ob_cnt_r <= s2_plan_r.k1 ? 2'd2 : 2'd1;
    end else if (ob_pop) begin
      ob_cnt_r <= ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_load) begin
      ob_r[0] <= res0;
      ob_r[1] <= res1;
    end else if (ob_pop) begin
      ob_r[0] <= ob_r[1];
    end
  end

  assign out_valid = ob_cnt_r != 2'd0;
  assign out_data  = ob_r[0];

  // checks
  a_ob_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= 2'd2)
    else $error("output buffer overfilled");

  a_lead_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(lead_r) <= LEAD_MAX)
    else $error("lead beyond traceback window");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_plan_r.k1 |-> s2_plan_r.k0)
    else $error("second flush byte without first");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_data_r.last_pair |=> clear_r && (lead_r == '0) && (bytes_r == 8'd0))
    else $error("trellis not restarted after last pair");

endmodule

// ===== verif/svd_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_stream_checker: decoded-byte predictor and scoreboard
// Watches the symbol, byte and limit channels, runs its own add-compare-select
// trellis per symbol pair and compares each byte transfer with the oldest
// predicted byte.
// ----------------------------------------------------------------------------
module svd_stream_checker
  import svd_pkg::*;
#(
  parameter int TRACEBACK_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  svd_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  svd_out_t   out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  // expected symbol pair per {state, input bit}, two bits each, entry 0 at the lsb
  localparam logic [31:0] BRANCH_CODES = 32'h9C63639C;

  // predicted decoder state
  logic [15:0] path_metric [NUM_TRELLIS_STATES];
  logic [15:0] survivor    [NUM_TRELLIS_STATES];
  logic [15:0] pair_idx;
  logic [15:0] bit_idx;
  logic [7:0]  sent_cnt;
  logic [7:0]  byte_limit;

  svd_out_t    decoded_q [$];
  int          errs;

  function automatic int level_dist(input logic [7:0] v, input logic one);
    int lvl;
    lvl = one ? int'(SOFT_ONE) : int'(SOFT_ZERO);
    return (int'(v) > lvl) ? int'(v) - lvl : lvl - int'(v);
  endfunction

  function automatic int branch_metric(input logic [2:0] st, input logic u,
                                       input logic [7:0] a, input logic [7:0] b);
    logic [1:0] code;
    code = BRANCH_CODES[2 * {st, u} +: 2];
    return level_dist(a, code[1]) + level_dist(b, code[0]);
  endfunction

  task automatic reset_trellis();
    for (int s = 0; s < NUM_TRELLIS_STATES; s++) begin
      path_metric[s] = COST_MAX;
      survivor[s]    = 16'd0;
    end
    path_metric[0] = 16'd0;
    pair_idx       = 16'd0;
    bit_idx        = 16'd0;
    sent_cnt       = 8'd0;
  endtask

  task automatic decode_pair(input svd_in_t pair);
    logic [15:0] next_cost [NUM_TRELLIS_STATES];
    logic [15:0] next_hist [NUM_TRELLIS_STATES];
    svd_out_t    got [2];
    logic [2:0]  p0, p1, win, best;
    logic [15:0] lead;
    logic        emit;
    int          c0, c1, shift, n_out;
    n_out = 0;
    // add-compare-select, first predecessor wins ties
    for (int t = 0; t < NUM_TRELLIS_STATES; t++) begin
      p0 = 3'(t >> 1);
      p1 = p0 | 3'd4;
      c0 = int'(path_metric[p0]) +
           branch_metric(p0, 1'(t & 1), pair.soft_first, pair.soft_second);
      c1 = int'(path_metric[p1]) +
           branch_metric(p1, 1'(t & 1), pair.soft_first, pair.soft_second);
      if (c0 > int'(COST_MAX)) c0 = int'(COST_MAX);
      if (c1 > int'(COST_MAX)) c1 = int'(COST_MAX);
      win          = (c1 < c0) ? p1 : p0;
      next_cost[t] = 16'((c1 < c0) ? c1 : c0);
      next_hist[t] = {survivor[win][14:0], win[0]};
    end
    for (int t = 0; t < NUM_TRELLIS_STATES; t++) begin
      path_metric[t] = next_cost[t];
      survivor[t]    = next_hist[t];
    end
    // regular traceback byte or end-of-packet flush, two at most
    for (int k = 0; k < 2; k++) begin
      lead = pair_idx - bit_idx;
      emit = (lead < 16'h8000) &&
             ((lead >= 16'(8 + TRACEBACK_DEPTH)) || (pair.last_pair && lead != 16'd0));
      if (emit) begin
        best = 3'd0;
        for (int s = 1; s < NUM_TRELLIS_STATES; s++) begin
          if (path_metric[s] < path_metric[best]) best = 3'(s);
        end
        // short lead: top up the history with the best state's own bit
        if (lead < 16'd8) begin
          survivor[best] = {survivor[best][14:0], best[0]};
          shift = 0;
        end else begin
          shift = int'(lead - 16'd8) & 15;
        end
        // bytes past the limit are decoded but dropped
        if (sent_cnt < byte_limit) begin
          got[n_out].data_byte  = 8'(survivor[best] >> shift);
          got[n_out].packet_end = 1'b0;
          n_out++;
          sent_cnt++;
        end
        bit_idx += 16'd8;
      end
    end
    pair_idx += 16'd1;
    if (pair.last_pair) begin
      if (n_out > 0) got[n_out - 1].packet_end = 1'b1;
      reset_trellis();
    end
    for (int k = 0; k < n_out; k++) decoded_q.push_back(got[k]);
  endtask

  task automatic check_byte(input svd_out_t seen);
    svd_out_t want;
    if (decoded_q.size() == 0) begin
      $error("unexpected byte transfer: data_byte %h packet_end %b",
             seen.data_byte, seen.packet_end);
      errs++;
    end else begin
      want = decoded_q.pop_front();
      if (seen.data_byte !== want.data_byte) begin
        $error("data_byte mismatch: expected %h actual %h", want.data_byte, seen.data_byte);
        errs++;
      end
      if (seen.packet_end !== want.packet_end) begin
        $error("packet_end mismatch: expected %b actual %b",
               want.packet_end, seen.packet_end);
        errs++;
      end
    end
  endtask

  // byte check first, then limit update, then the new pair
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_limit = 8'hFF;
      reset_trellis();
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) check_byte(out_data);
      if (cfg_valid && cfg_ready) byte_limit = cfg_data;
      if (in_valid && in_ready) decode_pair(in_data);
    end
    fail_count <= errs;
    pending    <= decoded_q.size();
  end

endmodule

// ===== verif/tb_soft_viterbi_decoder_k4_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_soft_viterbi_decoder_k4_top: stimulus and verdict for the viterbi decoder
// Sends directed and random packets of soft symbol pairs (noisy encoder output,
// random noise, cost-saturating runs) under several byte limits and pacing
// modes; the checker beside the block predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_soft_viterbi_decoder_k4_top;
  import svd_pkg::*;

  typedef enum int {PACE_NONE, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;
  typedef enum int {STYLE_CLEAN, STYLE_NOISY, STYLE_RANDOM, STYLE_SATURATE} pkt_style_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  svd_in_t    in_data;
  logic       out_valid;
  logic       out_ready = 1'b0;
  svd_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  int         fail_count;
  int         pending;
  int         gap_pct   = 0;
  int         stall_pct = 0;

  soft_viterbi_decoder_k4_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  svd_stream_checker #(.TRACEBACK_DEPTH(8)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // run limit
  initial begin
    #2_000_000;
    $display("soft_viterbi_decoder_k4_top verification failed");
    $finish;
  end

  task automatic set_pacing(input pace_t mode);
    case (mode)
      PACE_SEND_GAPS:   begin gap_pct = 46; stall_pct = 0;  end
      PACE_RECV_STALLS: begin gap_pct = 0;  stall_pct = 46; end
      PACE_BOTH:        begin gap_pct = 28; stall_pct = 28; end
      default:          begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // hold the symbol channel until every predicted byte has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pair(input svd_in_t item);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // ideal level of a code bit plus uniform noise, clamped to the byte range
  function automatic logic [7:0] soft_level(input logic one, input int amp);
    int v;
    v = (one ? int'(SOFT_ONE) : int'(SOFT_ZERO)) + int'($urandom_range(0, 2 * amp)) - amp;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // one packet; encoded styles follow a real encoder path from state zero
  task automatic send_packet(input int len, input pkt_style_t style);
    svd_in_t    item;
    logic [2:0] enc;
    logic [1:0] code;
    logic       u;
    int         amp;
    enc = 3'd0;
    amp = (style == STYLE_NOISY) ? 90 : 16;
    for (int i = 0; i < len; i++) begin
      u    = 1'($urandom);
      code = expect_code(enc, u);
      enc  = {enc[1:0], u};
      case (style)
        STYLE_RANDOM: begin
          item.soft_first  = 8'($urandom);
          item.soft_second = 8'($urandom);
        end
        STYLE_SATURATE: begin
          // every branch costs at least 128, so all path costs end up pinned
          item.soft_first  = $urandom_range(0, 1) ? 8'h80 : 8'h00;
          item.soft_second = $urandom_range(0, 1) ? 8'h80 : 8'h00;
        end
        default: begin
          item.soft_first  = soft_level(code[1], amp);
          item.soft_second = soft_level(code[0], amp);
          if ($urandom_range(0, 31) == 0) item.soft_second = 8'($urandom);
        end
      endcase
      item.last_pair = (i == len - 1);
      send_pair(item);
    end
  endtask

  // mostly encoded packets of short length, a few long, some pure noise
  task automatic random_packets(input int n_pairs);
    int         sent;
    int         len;
    int         pick;
    pkt_style_t style;
    sent = 0;
    while (sent < n_pairs) begin
      len   = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 40) : $urandom_range(41, 120);
      pick  = $urandom_range(0, 9);
      style = (pick < 5) ? STYLE_CLEAN : (pick < 8) ? STYLE_NOISY : STYLE_RANDOM;
      send_packet(len, style);
      sent += len;
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  // stimulus
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = 8'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lone pairs, a two-pair flush, a clean run, mid-level symbols
    set_pacing(PACE_NONE);
    send_pair('{8'h00, 8'hFF, 1'b1});
    send_pair('{8'hFF, 8'h00, 1'b1});
    send_pair('{SOFT_ZERO, SOFT_ONE, 1'b0});
    send_pair('{SOFT_ONE, SOFT_ZERO, 1'b1});
    send_packet(9, STYLE_CLEAN);
    for (int i = 0; i < 10; i++) send_pair('{8'h80, 8'h7F, 1'(i == 9)});
    drain();

    // limit zero: every byte dropped
    write_limit(8'd0);
    set_pacing(PACE_SEND_GAPS);
    random_packets(30);
    drain();

    write_limit(8'd1);
    set_pacing(PACE_RECV_STALLS);
    random_packets(40);
    drain();

    write_limit(8'd2);
    set_pacing(PACE_BOTH);
    random_packets(50);
    drain();

    write_limit(8'($urandom_range(3, 12)));
    set_pacing(PACE_NONE);
    random_packets(80);
    drain();

    write_limit(8'hFF);
    set_pacing(PACE_BOTH);
    random_packets(100);
    drain();

    // long packet that drives every path cost into saturation
    set_pacing(PACE_SEND_GAPS);
    send_packet(520, STYLE_SATURATE);
    drain();

    write_limit(8'($urandom_range(0, 255)));
    set_pacing(PACE_RECV_STALLS);
    random_packets(60);
    drain();

    write_limit(8'hFF);
    set_pacing(PACE_NONE);
    random_packets(40);
    drain();

    if (fail_count == 0) begin
      $display("soft_viterbi_decoder_k4_top verification clean");
    end else begin
      $display("soft_viterbi_decoder_k4_top verification failed");
    end
    $finish;
  end

endmodule
